// ===== rtl/bbff_pkg.sv =====
// Shared constants and types for the bitboard flood fill.
// Used by the fill cell and by the top level; no dependencies.
`default_nettype none

package bbff_pkg;

    // Fixed field widths of the stream payloads.
    localparam int ROW_W      = 19;
    localparam int ROW_NUM_W  = 5;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 24;

    // Default board edge length.
    localparam int BOARD_SIZE_DEF = 19;

    // Commands broadcast from the sequencer to every cell of the chain.
    typedef struct packed {
        logic load;
        logic clear;
        logic grow;
        logic shift;
    } cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/bbff_cell.sv =====
// One board row of the flood fill chain: occupancy and region registers.
// Depends on bbff_pkg; neighbours' region rows arrive from the cells above and below.
`default_nettype none

module bbff_cell
    import bbff_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
)
(
    input  wire logic             clk,
    input  wire cell_cmd_t        cmd,
    input  wire logic [CNT_W-1:0] row_count,
    input  wire logic [ROW_W-1:0] occ_in,
    input  wire logic [ROW_W-1:0] seed_in,
    input  wire logic [ROW_W-1:0] region_below,
    input  wire logic [ROW_W-1:0] region_above,
    output logic      [ROW_W-1:0] region,
    output logic                  changed
);

    logic [ROW_W-1:0] occ_reg;
    logic [ROW_W-1:0] region_reg;
    logic [ROW_W-1:0] region_next;
    logic             here;
    logic             unloaded;

    assign here     = (row_count == CNT_W'(INDEX));
    assign unloaded = (row_count <= CNT_W'(INDEX));

    // One dilation pass: left, right, up and down, masked by occupancy.
    assign region_next = (region_reg | (region_reg << 1) | (region_reg >> 1)
                          | region_below | region_above) & occ_reg;

    assign changed = (region_next != region_reg);
    assign region  = region_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load && here)
        begin
            occ_reg    <= occ_in;
            region_reg <= seed_in & occ_in;
        end
        else if (cmd.clear && unloaded)
        begin
            occ_reg    <= '0;
            region_reg <= '0;
        end
        else if (cmd.grow)
        begin
            region_reg <= region_next;
        end
        else if (cmd.shift)
        begin
            // Emission moves the board down one row per beat.
            region_reg <= region_above;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bitboard_flood_fill.sv =====
// Top level of the bitboard flood fill: stream ports, sequencer and the chain of row cells.
// Depends on bbff_pkg and bbff_cell.
`default_nettype none

// Rows are loaded bottom first, one beat per cycle; the beat with tlast set starts the
// fill. The ST_CLEAR state then clears the rows that were not loaded, after which the row
// chain performs one dilation pass per cycle, every cell updating its row from its
// neighbours at once, until a pass changes nothing; the number of passes is the greatest
// distance from a seed point to any point of the region, plus one for the pass that
// finds no change. The region then leaves as BOARD_SIZE beats, bottom row first, one per
// cycle while tready is high, with tlast on the top row. No input beat is taken after the
// final row until the last result beat has gone. Rows beyond BOARD_SIZE are dropped.
module bitboard_flood_fill
    import bbff_pkg::*;
#(
    parameter int BOARD_SIZE = BOARD_SIZE_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // s_tdata: occupancy_row [18:0], seed_row [37:19], zero pad [39:38]
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic                s_tlast,
    // m_tdata: row_number [4:0], region_row [23:5]
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [M_DATA_W-1:0] m_tdata,
    output logic                     m_tlast
);

    localparam int CNT_W = $clog2(BOARD_SIZE + 1);
    localparam logic [ROW_W-1:0] COL_MASK =
        (BOARD_SIZE >= ROW_W) ? {ROW_W{1'b1}} : ROW_W'((1 << BOARD_SIZE) - 1);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_CLEAR,
        ST_FILL,
        ST_EMIT
    } state_t;

    state_t                 state_reg;
    logic [CNT_W-1:0]       load_cnt_reg;
    logic [ROW_NUM_W-1:0]   emit_cnt_reg;

    cell_cmd_t              cmd;
    logic                   s_beat;
    logic                   m_beat;
    logic                   any_changed;
    logic [ROW_W-1:0]       occ_in;
    logic [ROW_W-1:0]       seed_in;
    logic [ROW_W-1:0]       region   [BOARD_SIZE];
    logic [BOARD_SIZE-1:0]  changed;

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign s_beat   = s_tvalid && s_tready;
    assign m_beat   = m_tvalid && m_tready;

    assign occ_in  = s_tdata[ROW_W-1:0] & COL_MASK;
    assign seed_in = s_tdata[2*ROW_W-1:ROW_W] & COL_MASK;

    assign cmd.load  = s_beat && (load_cnt_reg < CNT_W'(BOARD_SIZE));
    assign cmd.clear = (state_reg == ST_CLEAR);
    assign cmd.grow  = (state_reg == ST_FILL);
    assign cmd.shift = m_beat;

    assign any_changed = |changed;

    assign m_tdata = {region[0], emit_cnt_reg};
    assign m_tlast = (emit_cnt_reg == ROW_NUM_W'(BOARD_SIZE - 1));

    for (genvar i = 0; i < BOARD_SIZE; i++)
    begin : g_row
        logic [ROW_W-1:0] below;
        logic [ROW_W-1:0] above;

        if (i == 0)
        begin : g_bottom
            assign below = '0;
        end
        else
        begin : g_mid_below
            assign below = region[i-1];
        end

        if (i == BOARD_SIZE - 1)
        begin : g_top
            assign above = '0;
        end
        else
        begin : g_mid_above
            assign above = region[i+1];
        end

        bbff_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk          (clk),
            .cmd          (cmd),
            .row_count    (load_cnt_reg),
            .occ_in       (occ_in),
            .seed_in      (seed_in),
            .region_below (below),
            .region_above (above),
            .region       (region[i]),
            .changed      (changed[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            load_cnt_reg <= '0;
            emit_cnt_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_LOAD:
                begin
                    if (cmd.load)
                    begin
                        load_cnt_reg <= load_cnt_reg + 1'b1;
                    end
                    if (s_beat && s_tlast)
                    begin
                        state_reg <= ST_CLEAR;
                    end
                end
                ST_CLEAR:
                begin
                    state_reg <= ST_FILL;
                end
                ST_FILL:
                begin
                    // A pass that leaves every row as it was ends the fill.
                    if (!any_changed)
                    begin
                        state_reg    <= ST_EMIT;
                        load_cnt_reg <= '0;
                        emit_cnt_reg <= '0;
                    end
                end
                ST_EMIT:
                begin
                    if (m_beat)
                    begin
                        emit_cnt_reg <= emit_cnt_reg + 1'b1;
                        if (m_tlast)
                        begin
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input and output sides active together");

    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[ROW_NUM_W-1:0] == ROW_NUM_W'(BOARD_SIZE - 1))
        else $error("tlast not on the top row");

    a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        m_beat && m_tlast |=> s_tready && load_cnt_reg == '0)
        else $error("block did not return to loading after the board");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        load_cnt_reg <= CNT_W'(BOARD_SIZE))
        else $error("load row count beyond the board");

    a_fill_start: assert property (@(posedge clk) disable iff (!rst_n)
        s_beat && s_tlast |=> state_reg == ST_CLEAR)
        else $error("final row did not start the fill");
`endif

endmodule

`default_nettype wire

// ===== bench/bitboard_flood_fill_tb.sv =====
// Self-checking testbench for bitboard_flood_fill: boards are streamed in row by row and
// every region row that comes out is compared with a fill computed inside the bench.
// Depends on bbff_pkg and the bitboard_flood_fill RTL only.
module bitboard_flood_fill_tb
    import bbff_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BOARD = BOARD_SIZE_DEF;
    localparam logic [ROW_W-1:0] COL_MASK = ROW_W'((64'd1 << BOARD) - 64'd1);
    localparam logic [ROW_W-1:0] ALL_ONES = '1;

    typedef struct packed {
        logic [ROW_NUM_W-1:0] row_number;
        logic [ROW_W-1:0]     region;
        logic                 end_of_board;
    } region_beat_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    // s_tdata: occupancy_row [18:0], seed_row [37:19], zero pad [39:38]
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // m_tdata: row_number [4:0], region_row [23:5]
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;

    // Bench copy of the board as the block should hold it.
    logic [ROW_W-1:0] occupied_rows [BOARD];
    logic [ROW_W-1:0] region_rows [BOARD];
    int               rows_loaded = 0;

    region_beat_t     pending_region_beats [$];
    region_beat_t     want_beat;
    int               mismatch_count = 0;

    int               send_gap_pct = 0;
    int               take_gap_pct = 0;
    int               hold_request = 0;
    int               hold_left = 0;

    bitboard_flood_fill #(
        .BOARD_SIZE(BOARD)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Grow the region by its four neighbours until a pass leaves it unchanged.
    function automatic void flood_region();
        logic [ROW_W-1:0] grown [BOARD];
        logic [ROW_W-1:0] cur;
        bit               changed;
        changed = 1'b1;
        while (changed)
        begin
            changed = 1'b0;
            for (int r = 0; r < BOARD; r++)
            begin
                cur = region_rows[r];
                grown[r] = cur | (cur << 1) | (cur >> 1);
                if (r > 0)
                    grown[r] |= region_rows[r-1];
                if (r < BOARD - 1)
                    grown[r] |= region_rows[r+1];
                grown[r] &= occupied_rows[r] & COL_MASK;
            end
            for (int r = 0; r < BOARD; r++)
            begin
                if (grown[r] != region_rows[r])
                    changed = 1'b1;
                region_rows[r] = grown[r];
            end
        end
    endfunction

    // Called for every accepted input beat; queues a whole board of region rows on tlast.
    function automatic void load_and_fill(input logic [ROW_W-1:0] occ,
                                          input logic [ROW_W-1:0] seed,
                                          input logic             last);
        region_beat_t beat;
        if (rows_loaded < BOARD)
        begin
            occupied_rows[rows_loaded] = occ & COL_MASK;
            region_rows[rows_loaded] = seed & occ & COL_MASK;
            rows_loaded++;
        end
        if (last)
        begin
            // Rows that never arrived count as empty.
            for (int r = rows_loaded; r < BOARD; r++)
            begin
                occupied_rows[r] = '0;
                region_rows[r] = '0;
            end
            flood_region();
            for (int r = 0; r < BOARD; r++)
            begin
                beat.row_number = ROW_NUM_W'(r);
                beat.region = region_rows[r];
                beat.end_of_board = (r == BOARD - 1);
                pending_region_beats.insert(pending_region_beats.size(), beat);
            end
            rows_loaded = 0;
        end
    endfunction

    // Entered and left at a falling edge; the row stays offered until it is taken.
    task automatic send_row(input logic [ROW_W-1:0] occ, input logic [ROW_W-1:0] seed,
                            input logic last);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, seed, occ};
        s_tlast <= last;
        do
            @(posedge clk);
        while (!s_tready);
        load_and_fill(occ, seed, last);
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= take_gap_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_region_beats.size() == 0)
            begin
                $display("%0t: unexpected region beat, row %0d region %05h last %0b", $time,
                         m_tdata[4:0], m_tdata[23:5], m_tlast);
                mismatch_count++;
            end
            else
            begin
                want_beat = pending_region_beats.pop_front();
                if (m_tdata[4:0] !== want_beat.row_number)
                begin
                    $display("%0t: row_number expected %0d, actual %0d", $time,
                             want_beat.row_number, m_tdata[4:0]);
                    mismatch_count++;
                end
                if (m_tdata[23:5] !== want_beat.region)
                begin
                    $display("%0t: region_row %0d expected %05h, actual %05h", $time,
                             want_beat.row_number, want_beat.region, m_tdata[23:5]);
                    mismatch_count++;
                end
                if (m_tlast !== want_beat.end_of_board)
                begin
                    $display("%0t: end_of_board row %0d expected %0b, actual %0b", $time,
                             want_beat.row_number, want_beat.end_of_board, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // One-row boards at the extremes of both fields, seeds off the occupied points included.
    task automatic test_single_row_boards();
        send_row(ALL_ONES, ALL_ONES, 1'b1);
        send_row('0, ALL_ONES, 1'b1);
        send_row(ALL_ONES, '0, 1'b1);
        send_row(19'h2AAAA, 19'h55555, 1'b1);
    endtask

    // The seed sits in the lower row and must climb into the upper one.
    task automatic test_two_row_board();
        send_row(19'h00001, 19'h00001, 1'b0);
        send_row(19'h7FFFF, 19'h00000, 1'b1);
    endtask

    // Full board laid out as a serpentine corridor, which gives the longest fill. A 20th
    // row is dropped by the block yet its tlast still starts the fill.
    task automatic test_serpentine_overflow();
        logic [ROW_W-1:0] occ;
        for (int r = 0; r < BOARD; r++)
        begin
            if (r % 2 == 0)
                occ = ALL_ONES;
            else if (r % 4 == 1)
                occ = ROW_W'(1) << (ROW_W - 1);
            else
                occ = ROW_W'(1);
            send_row(occ, (r == 0) ? ROW_W'(1) : '0, 1'b0);
        end
        send_row(ALL_ONES, ALL_ONES, 1'b1);
    endtask

    // Mostly complete boards with random content; some short, some overlong, some noisy.
    task automatic test_random_boards(input int budget);
        int               sent;
        int               len;
        int               pick;
        int               style;
        int               seed_at;
        logic [ROW_W-1:0] occ;
        logic [ROW_W-1:0] seed;
        sent = 0;
        while (sent < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
                len = BOARD;
            else if (pick < 85)
                len = $urandom_range(BOARD - 1, 1);
            else
                len = $urandom_range(BOARD + 3, BOARD + 1);
            style = $urandom_range(4);
            seed_at = $urandom_range(len - 1);
            for (int r = 0; r < len; r++)
            begin
                case (style)
                    0: occ = ROW_W'($urandom);
                    1: occ = ROW_W'($urandom | $urandom);
                    2: occ = ROW_W'($urandom & $urandom);
                    default: occ = ROW_W'(~($urandom & $urandom & $urandom));
                endcase
                if (style == 4)
                    seed = ROW_W'($urandom);
                else if (r == seed_at)
                    seed = ROW_W'(1) << $urandom_range(ROW_W - 1);
                else if ($urandom_range(9) == 0)
                    seed = ROW_W'($urandom & $urandom & $urandom);
                else
                    seed = '0;
                send_row(occ, seed, r == len - 1);
            end
            sent += len;
        end
    endtask

    // The receiver stops for a long stretch while the next board is already on offer,
    // so the block has to hold its input back until the region has drained.
    task automatic test_stalled_output();
        hold_request = 150;
        for (int r = 0; r < BOARD; r++)
            send_row(ROW_W'(~($urandom & $urandom)), (r == 3) ? ROW_W'($urandom) : '0,
                     r == BOARD - 1);
        send_row(ROW_W'($urandom), ROW_W'($urandom), 1'b0);
        send_row(ROW_W'($urandom), ROW_W'($urandom), 1'b1);
    endtask

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_gap_pct = 17;
        take_gap_pct = 76;
        test_single_row_boards();
        test_two_row_board();
        test_serpentine_overflow();
        test_random_boards(14);

        send_gap_pct = 76;
        take_gap_pct = 17;
        test_random_boards(12);

        send_gap_pct = 0;
        take_gap_pct = 0;
        test_stalled_output();
        test_random_boards(10);

        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;
        wait (pending_region_beats.size() == 0);
        repeat (400) @(posedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #400_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/bbff_pkg.sv
rtl/bbff_cell.sv
rtl/bitboard_flood_fill.sv
bench/bitboard_flood_fill_tb.sv
